// ===== rtl/positional_list_table_defines.svh =====
// Assertion macros shared by the checker of the positional list table.
`ifndef POSITIONAL_LIST_TABLE_DEFINES_SVH
`define POSITIONAL_LIST_TABLE_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define PLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define PLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked through reset.
`define PLT_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/plt_pkg.sv =====
// Package with constants, codes and types of the positional list table.
package plt_pkg;

  localparam int CAPACITY  = 16;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int POS_W     = 5;
  localparam int ST_W      = 3;
  localparam int FIDX_W    = 4;
  localparam int CNTF_W    = 5;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 16;

  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd5;
  localparam logic [OP_W-1:0] OP_DEL_VALUE = 3'd6;
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd7;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd4;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd5;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic              cmp;
    logic              ins;
    logic              del;
    logic [CNT_W-1:0]  at;
    logic [DATA_W-1:0] data;
  } plt_cmd_t;

endpackage

// ===== rtl/plt_cell.sv =====
// One storage cell of the list: holds an entry, compares it and shifts it.
module plt_cell (
  input  logic                        clk,
  input  plt_pkg::plt_cmd_t           cmd,
  input  logic [plt_pkg::IDX_W-1:0]   cell_idx,
  input  logic [plt_pkg::CNT_W-1:0]   count,
  input  logic [plt_pkg::DATA_W-1:0]  left_data,
  input  logic [plt_pkg::DATA_W-1:0]  right_data,
  output logic [plt_pkg::DATA_W-1:0]  entry,
  output logic                        match
);
  import plt_pkg::*;

  logic [DATA_W-1:0] entry_r;
  logic              match_r;
  logic [CNT_W-1:0]  idx_ext;

  assign idx_ext = CNT_W'(cell_idx);

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      match_r <= (entry_r == cmd.data) && (idx_ext < count);
    end
    if (cmd.ins) begin
      if (idx_ext > cmd.at) begin
        entry_r <= left_data;
      end else if (idx_ext == cmd.at) begin
        entry_r <= cmd.data;
      end
    end else if (cmd.del) begin
      if (idx_ext >= cmd.at) begin
        entry_r <= right_data;
      end
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

// ===== rtl/positional_list_table.sv =====
// Top level of the positional list table: controller and the row of cells.
//
//   Channel  Direction  Handshake          Payload
//   in_      slave      tvalid / tready    tdata: operation, value, position
//   out_     master     tvalid / tready    tdata: status, found_index, entry_count
//
// In the accepting cycle every cell compares its entry with the request
// value and registers a match flag; in the apply state the controller
// priority-encodes the flags, decides the status and broadcasts at most
// one shift command that all cells perform together. The result goes to
// an output register, so a new request is taken while a result still
// waits; a stalled result holds the controller in its apply state. Reset
// (rst_n low, synchronous) clears the count and the control
// state at once; the cells need no clearing since only occupied entries
// are ever read.
module positional_list_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [2:0] operation, [34:3] value, [39:35] position
  input  logic [plt_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [2:0] status, [6:3] found_index, [11:7] entry_count, [15:12] zero
  output logic [plt_pkg::OUT_W-1:0]    out_tdata
);
  import plt_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic                state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [OP_W-1:0]     op_r;
  logic [DATA_W-1:0]   value_r;
  logic [POS_W-1:0]    pos_r;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r;

  logic                in_fire;
  logic                apply_go;
  plt_cmd_t            cmd;

  logic [DATA_W-1:0]   entries [CAPACITY];
  logic [CAPACITY-1:0] hit_vec;

  // Decision signals for the apply cycle.
  logic                any_match;
  logic [IDX_W-1:0]    first_idx;
  logic                list_full;
  logic                list_empty;
  logic [CMP_W-1:0]    pos_c;
  logic [CMP_W-1:0]    cnt_c;
  logic [ST_W-1:0]     status;
  logic [FIDX_W-1:0]   found;
  logic                do_ins;
  logic                do_del;
  logic [CNT_W-1:0]    at;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign apply_go  = (state_r == S_APPLY) && (!out_valid_r || out_tready);

  // The chain of cells. Each cell sees its neighbors' entries for shifting.
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] left_d;
      logic [DATA_W-1:0] right_d;
      if (g == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = entries[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = entries[g+1];
      end
      plt_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .cell_idx   (IDX_W'(g)),
        .count      (count_r),
        .left_data  (left_d),
        .right_data (right_d),
        .entry      (entries[g]),
        .match      (hit_vec[g])
      );
    end
  endgenerate

  // First matching cell; match flags are already limited to occupied cells.
  always_comb begin
    first_idx = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (hit_vec[k]) begin
        first_idx = IDX_W'(k);
      end
    end
  end

  assign any_match  = |hit_vec;
  assign list_full  = (count_r == CNT_W'(CAPACITY));
  assign list_empty = (count_r == '0);
  assign pos_c      = CMP_W'(pos_r);
  assign cnt_c      = CMP_W'(count_r);

  // Status and the shift command for the pending request.
  always_comb begin
    status    = ST_OK;
    found     = '0;
    do_ins    = 1'b0;
    do_del    = 1'b0;
    at        = '0;
    count_nxt = count_r;
    case (op_r)
      OP_INS_AT: begin
        if (any_match) begin
          status = ST_DUP;
        end else if (pos_c > cnt_c) begin
          status = ST_BADPOS;
        end else if (list_full) begin
          status = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          at        = CNT_W'(pos_c);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_INS_FRONT, OP_INS_BACK: begin
        if (any_match) begin
          status = ST_DUP;
        end else if (list_full) begin
          status = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          at        = (op_r == OP_INS_BACK) ? count_r : '0;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DEL_AT: begin
        if (list_empty) begin
          status = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          status = ST_BADPOS;
        end else begin
          do_del    = 1'b1;
          at        = CNT_W'(pos_c);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_DEL_FRONT: begin
        if (list_empty) begin
          status = ST_EMPTY;
        end else begin
          do_del    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_DEL_BACK: begin
        // The last entry simply drops out of the occupied range.
        if (list_empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_DEL_VALUE: begin
        if (list_empty) begin
          status = ST_EMPTY;
        end else if (!any_match) begin
          status = ST_NOTFOUND;
        end else begin
          do_del    = 1'b1;
          at        = CNT_W'(first_idx);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        if (!any_match) begin
          status = ST_NOTFOUND;
        end else begin
          found = FIDX_W'(first_idx);
        end
      end
    endcase
  end

  // Compare in the accepting cycle against the incoming value, shift in the
  // apply cycle with the held value.
  always_comb begin
    cmd.cmp  = in_fire;
    cmd.ins  = apply_go && do_ins;
    cmd.del  = apply_go && do_del;
    cmd.at   = at;
    cmd.data = (state_r == S_IDLE) ? in_tdata[34:3] : value_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (apply_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (apply_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (apply_go) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_tdata[2:0];
      value_r <= in_tdata[34:3];
      pos_r   <= in_tdata[39:35];
    end
    if (apply_go) begin
      out_data_r <= {4'b0000, CNTF_W'(count_nxt), found, status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/plt_checker.sv =====
// Port-level checker of the positional list table and its bind statement.
`include "positional_list_table_defines.svh"

module plt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [plt_pkg::IN_W-1:0]   in_tdata,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [plt_pkg::OUT_W-1:0]  out_tdata
);
  import plt_pkg::*;

  // No result may appear out of reset.
  `PLT_ASSERT_RST(a_rst_quiet, !rst_n, !out_tvalid, "result valid right after reset")

  // A stalled result stays and keeps its payload.
  `PLT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // One request at a time: after a transaction the input is not ready.
  `PLT_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "request taken while one is in flight")

  // The reported count never exceeds the capacity.
  `PLT_ASSERT_NOW(a_count_range, out_tvalid, out_tdata[11:7] <= CNTF_W'(CAPACITY), "entry count out of range")

  // Status codes stay within the defined set.
  `PLT_ASSERT_NOW(a_status_range, out_tvalid, out_tdata[2:0] <= ST_NOTFOUND, "undefined status code")

endmodule

bind positional_list_table plt_checker u_plt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
